// ----- rtl/lsta_pkg.sv -----
`timescale 1ns / 1ps

package lsta_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int OP_W       = 2;
   localparam int NODE_W     = 16;
   localparam int WORD_W     = 32;
   localparam int TEMP_W     = 16;
   localparam int SMOKE_W    = 16;
   localparam int SLOT_W     = 5;
   localparam int AGED_W     = 6;
   localparam int TIMEOUT_W  = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_UPSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_AGE    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE      = 1'd1;

   localparam logic [TIMEOUT_W-1:0] STALE_TIMEOUT_RST = 31'd30000;
   localparam logic [NODE_W-1:0]    OWN_NODE_RST      = 16'd0;

   // decay arithmetic: new cost = cost + floor(cost * m / 6000), 6000 = 16 * 375
   localparam int                 SPAN_W      = 16;
   localparam logic [SPAN_W-1:0]  AGE_SPAN_MS = 16'd60000;
   localparam int                 PROD_W      = WORD_W + SPAN_W;
   localparam int                 DIV_SHIFT   = 4;
   localparam int                 DIVISOR     = 375;
   localparam int                 DIGIT_W     = 4;
   localparam int                 DIV_STEPS   = (PROD_W - DIV_SHIFT) / DIGIT_W;
   localparam int                 DIG_W       = $clog2(DIV_STEPS);
   localparam int                 REM_W       = $clog2(DIVISOR);
   localparam int                 DIGV_W      = REM_W + DIGIT_W;
   localparam int                 QUO_W       = WORD_W + 4;
   localparam int                 SUM_W       = QUO_W + 1;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [NODE_W-1:0]        node;
      logic [WORD_W-1:0]        sequence_req;
      logic [WORD_W-1:0]        now_time;
      logic [WORD_W-1:0]        cost_in;
      logic signed [TEMP_W-1:0] temperature_in;
      logic [SMOKE_W-1:0]       smoke_in;
      logic                     flame_in;
   } item_type;

   typedef struct packed {
      logic                     found;
      logic [SLOT_W-1:0]        slot;
      logic                     dropped;
      logic [WORD_W-1:0]        sequence_out;
      logic [WORD_W-1:0]        updated_time;
      logic [WORD_W-1:0]        cost_out;
      logic signed [TEMP_W-1:0] temperature_out;
      logic [SMOKE_W-1:0]       smoke_out;
      logic                     flame_out;
      logic [AGED_W-1:0]        aged_entries;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node;
      logic [WORD_W-1:0]        seq_num;
      logic [WORD_W-1:0]        update_time;
      logic [WORD_W-1:0]        cost;
      logic signed [TEMP_W-1:0] temperature;
      logic [SMOKE_W-1:0]       smoke;
      logic                     flame;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic scan;
      logic take_hit;
      logic take_rec;
      logic up_write;
      logic append;
      logic set_drop;
      logic age_rd;
      logic age_load;
      logic div_step;
      logic age_wr;
      logic deliver;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic             hit;
      logic             scan_end;
      logic             full;
      logic             age_end;
      logic             stale;
      logic             div_last;
      logic             out_free;
      logic [CNT_W-1:0] count;
   } sts_type;

   // quotient digit of v / 375 for v < 16 * 375
   function automatic logic [DIGIT_W-1:0] div_digit(input logic [DIGV_W-1:0] v);
      logic [DIGIT_W-1:0] d;
      d = '0;
      for (int k = 1; k < (1 << DIGIT_W); k++) begin
         if (v >= DIGV_W'(DIVISOR * k)) d = DIGIT_W'(k);
      end
      return d;
   endfunction

   function automatic logic [DIGV_W-1:0] digit_times(input logic [DIGIT_W-1:0] d);
      return DIGV_W'(DIVISOR * int'(d));
   endfunction

endpackage

// ----- rtl/lsta_if.sv -----
`timescale 1ns / 1ps

interface lsta_req_if import lsta_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [NODE_W-1:0]        node;
   logic [WORD_W-1:0]        sequence_req;
   logic [WORD_W-1:0]        now_time;
   logic [WORD_W-1:0]        cost_in;
   logic signed [TEMP_W-1:0] temperature_in;
   logic [SMOKE_W-1:0]       smoke_in;
   logic                     flame_in;

   modport source (output valid, op, node, sequence_req, now_time, cost_in,
                   temperature_in, smoke_in, flame_in, input ready);
   modport sink (input valid, op, node, sequence_req, now_time, cost_in,
                 temperature_in, smoke_in, flame_in, output ready);
endinterface

interface lsta_rsp_if import lsta_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [SLOT_W-1:0]        slot;
   logic                     dropped;
   logic [WORD_W-1:0]        sequence_out;
   logic [WORD_W-1:0]        updated_time;
   logic [WORD_W-1:0]        cost_out;
   logic signed [TEMP_W-1:0] temperature_out;
   logic [SMOKE_W-1:0]       smoke_out;
   logic                     flame_out;
   logic [AGED_W-1:0]        aged_entries;

   modport source (output valid, found, slot, dropped, sequence_out, updated_time,
                   cost_out, temperature_out, smoke_out, flame_out, aged_entries,
                   input ready);
   modport sink (input valid, found, slot, dropped, sequence_out, updated_time,
                 cost_out, temperature_out, smoke_out, flame_out, aged_entries,
                 output ready);
endinterface

interface lsta_csr_if import lsta_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/link_state_table_with_aging.sv -----
`timescale 1ns / 1ps
// search: upsert or lookup over n stored entries, one entry per cycle
//   through the single table read port
// age: a walk over all n entries, each stale one through the radix-16 divider and write-back
// handoff: one item at a time, the next is taken in the cycle after the result is loaded
// reset: synchronous, clears the entry count and loads stale_timeout 30000 and own_node 0;
//   table contents are not cleared and no clearing pass runs

module link_state_table_with_aging import lsta_pkg::*; (
   input logic      clock,
   input logic      reset,
   lsta_req_if.sink   req_ch,
   lsta_rsp_if.source rsp_ch,
   lsta_csr_if.sink   csr_ch
);

   cmd_type  cmd;
   sts_type  sts;
   item_type req_item;
   rsp_type  rsp_item;
   logic     rsp_valid;
   logic     req_ready;
   logic     csr_ready;

   // pack the input item
   always_comb begin
      req_item                = '0;
      req_item.op             = req_ch.op;
      req_item.node           = req_ch.node;
      req_item.sequence_req   = req_ch.sequence_req;
      req_item.now_time       = req_ch.now_time;
      req_item.cost_in        = req_ch.cost_in;
      req_item.temperature_in = req_ch.temperature_in;
      req_item.smoke_in       = req_ch.smoke_in;
      req_item.flame_in       = req_ch.flame_in;
   end

   // sequencer: search, append, aging walk and output handoff
   lsta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table memory, decay arithmetic, result and config registers
   lsta_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (rsp_item)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = csr_ready;

   // result item out of the output register
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.found           = rsp_item.found;
   assign rsp_ch.slot            = rsp_item.slot;
   assign rsp_ch.dropped         = rsp_item.dropped;
   assign rsp_ch.sequence_out    = rsp_item.sequence_out;
   assign rsp_ch.updated_time    = rsp_item.updated_time;
   assign rsp_ch.cost_out        = rsp_item.cost_out;
   assign rsp_ch.temperature_out = rsp_item.temperature_out;
   assign rsp_ch.smoke_out       = rsp_item.smoke_out;
   assign rsp_ch.flame_out       = rsp_item.flame_out;
   assign rsp_ch.aged_entries    = rsp_item.aged_entries;

   // entry count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.count <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // entry count only grows, one entry at a time
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (sts.count == $past(sts.count)) || (sts.count == $past(sts.count) + 1'b1))
      else $error("entry count jumped");

   // an accepted item keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while another is in flight");

   // a refused upsert reports nothing else
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.dropped) |-> (!rsp_ch.found && (rsp_ch.slot == '0)
         && (rsp_ch.aged_entries == '0)))
      else $error("dropped result carries other fields");

endmodule

// ----- rtl/lsta_ram.sv -----
`timescale 1ns / 1ps

module lsta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lsta_ctrl.sv -----
`timescale 1ns / 1ps

module lsta_ctrl import lsta_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_FIND    = 3'd2;
   localparam logic [2:0] S_AGE_RD  = 3'd3;
   localparam logic [2:0] S_AGE_CHK = 3'd4;
   localparam logic [2:0] S_AGE_DIV = 3'd5;
   localparam logic [2:0] S_AGE_WR  = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.op) inside
               OP_UPSERT, OP_LOOKUP: state_in = S_FIND;
               OP_AGE:               state_in = S_AGE_RD;
               default:              state_in = S_DONE;
            endcase
         end
         S_FIND: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               if (sts.op == OP_LOOKUP) cmd.take_rec = 1'b1;
               else cmd.up_write = 1'b1;
               state_in = S_DONE;
            end else if (sts.scan_end) begin
               if (sts.op == OP_UPSERT) begin
                  if (sts.full) begin
                     cmd.set_drop = 1'b1;
                  end else begin
                     cmd.up_write = 1'b1;
                     cmd.append   = 1'b1;
                  end
               end
               state_in = S_DONE;
            end
         end
         S_AGE_RD: begin
            if (sts.age_end) begin
               state_in = S_DONE;
            end else begin
               cmd.age_rd = 1'b1;
               state_in   = S_AGE_CHK;
            end
         end
         S_AGE_CHK: begin
            if (sts.stale) begin
               cmd.age_load = 1'b1;
               state_in     = S_AGE_DIV;
            end else begin
               state_in = S_AGE_RD;
            end
         end
         S_AGE_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_AGE_WR;
         end
         S_AGE_WR: begin
            cmd.age_wr = 1'b1;
            state_in   = S_AGE_RD;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/lsta_dp.sv -----
`timescale 1ns / 1ps

module lsta_dp import lsta_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  item_type              req_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_item
);

   // registers
   item_type              item_ff, item_in;
   rsp_type               res_ff, res_in;
   rsp_type               out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [PROD_W-1:0]     div_ff, div_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [DIG_W-1:0]      dig_ff, dig_in;
   logic                  fl_set_ff, fl_set_in;
   logic [TIMEOUT_W-1:0]  stale_ff, stale_in;
   logic [NODE_W-1:0]     own_ff, own_in;

   // memory port
   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr;
   entry_type             wr_row, row, item_row, aged_row;
   logic [ENTRY_W-1:0]    rd_data;

   // arithmetic
   logic                  hit, issue, fl_hit;
   logic [WORD_W-1:0]     elapsed, timeout_x, over;
   logic [SPAN_W-1:0]     span;
   logic [WORD_W:0]       flame_limit;
   logic [PROD_W-1:0]     product;
   logic [DIGV_W-1:0]     div_v;
   logic [DIGIT_W-1:0]    div_q;
   logic [SUM_W-1:0]      cost_sum;
   logic [WORD_W-1:0]     new_cost;

   lsta_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign row = entry_type'(rd_data);

   // search
   assign hit   = pend_ff && (row.node == item_ff.node);
   assign issue = cmd.scan && !hit && (idx_ff < cnt_ff);
   assign rd_en = issue || cmd.age_rd;

   // staleness and decay factor
   assign timeout_x   = {1'b0, stale_ff};
   assign elapsed     = item_ff.now_time - row.update_time;
   assign over        = elapsed - timeout_x;
   assign span        = (over < {16'd0, AGE_SPAN_MS}) ? over[SPAN_W-1:0] : AGE_SPAN_MS;
   assign flame_limit = {2'b00, stale_ff} + {1'b0, stale_ff, 1'b0};
   assign fl_hit      = {1'b0, elapsed} > flame_limit;
   assign product     = PROD_W'(row.cost) * PROD_W'(span);

   // one radix-16 digit of (product >> 4) / 375 per step
   assign div_v = {rem_ff, div_ff[PROD_W-1 -: DIGIT_W]};
   assign div_q = div_digit(div_v);

   assign cost_sum = SUM_W'(row.cost) + SUM_W'(quo_ff);
   assign new_cost = (cost_sum[SUM_W-1:WORD_W] != '0) ? '1 : cost_sum[WORD_W-1:0];

   always_comb begin
      item_row             = '0;
      item_row.node        = item_ff.node;
      item_row.seq_num     = item_ff.sequence_req;
      item_row.update_time = item_ff.now_time;
      item_row.cost        = item_ff.cost_in;
      item_row.temperature = item_ff.temperature_in;
      item_row.smoke       = item_ff.smoke_in;
      item_row.flame       = item_ff.flame_in;
      aged_row       = row;
      aged_row.cost  = new_cost;
      aged_row.flame = row.flame | fl_set_ff;
   end

   assign wr_en   = cmd.up_write || cmd.age_wr;
   assign wr_addr = (cmd.append && !cmd.age_wr) ? cnt_ff[ADDR_W-1:0] : pend_idx_ff;
   assign wr_row  = cmd.age_wr ? aged_row : item_row;

   always_comb begin
      item_in      = item_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_in      = rd_en;
      pend_idx_in  = rd_en ? idx_ff[ADDR_W-1:0] : pend_idx_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dig_in       = dig_ff;
      fl_set_in    = fl_set_ff;
      stale_in     = stale_ff;
      own_in       = own_ff;

      if (cmd.latch) begin
         item_in = req_item;
         res_in  = '0;
         idx_in  = '0;
      end
      if (rd_en) idx_in = idx_ff + 1'b1;

      if (cmd.take_hit) begin
         res_in.found = 1'b1;
         res_in.slot  = SLOT_W'(pend_idx_ff);
      end
      if (cmd.take_rec) begin
         res_in.sequence_out    = row.seq_num;
         res_in.updated_time    = row.update_time;
         res_in.cost_out        = row.cost;
         res_in.temperature_out = row.temperature;
         res_in.smoke_out       = row.smoke;
         res_in.flame_out       = row.flame;
      end
      if (cmd.up_write && cmd.append) begin
         res_in.slot = SLOT_W'(cnt_ff);
         cnt_in      = cnt_ff + 1'b1;
      end
      if (cmd.set_drop) res_in.dropped = 1'b1;

      if (cmd.age_load) begin
         div_in    = product;
         rem_in    = '0;
         quo_in    = '0;
         dig_in    = '0;
         fl_set_in = fl_hit;
      end
      if (cmd.div_step) begin
         div_in = div_ff << DIGIT_W;
         rem_in = REM_W'(div_v - digit_times(div_q));
         quo_in = {quo_ff[QUO_W-DIGIT_W-1:0], div_q};
         dig_in = dig_ff + 1'b1;
      end
      if (cmd.age_wr) res_in.aged_entries = res_ff.aged_entries + 1'b1;

      if (cmd.deliver) begin
         out_in       = res_ff;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_STALE_TIMEOUT: stale_in = csr_data[TIMEOUT_W-1:0];
            CSR_OWN_NODE:      own_in   = csr_data[NODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         dig_ff       <= '0;
         stale_ff     <= STALE_TIMEOUT_RST;
         own_ff       <= OWN_NODE_RST;
      end else begin
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         dig_ff       <= dig_in;
         stale_ff     <= stale_in;
         own_ff       <= own_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      pend_idx_ff <= pend_idx_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      fl_set_ff   <= fl_set_in;
   end

   always_comb begin
      sts          = '0;
      sts.op       = item_ff.op;
      sts.hit      = hit;
      sts.scan_end = !hit && (idx_ff >= cnt_ff);
      sts.full     = (cnt_ff >= CNT_W'(TABLE_DEPTH));
      sts.age_end  = (idx_ff >= cnt_ff);
      sts.stale    = (elapsed > timeout_x) && (row.node != own_ff);
      sts.div_last = (dig_ff == DIG_W'(DIV_STEPS - 1));
      sts.out_free = !out_valid_ff || rsp_ready;
      sts.count    = cnt_ff;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule
